@@ src/ray_triangle_intersect_core_defines.svh @@
// ----------------------------------------------------------------------------
// Ray/triangle intersect core assertion macros
// Shared concurrent assertion forms used by the core.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_CORE_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_DEFINES_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersect package
// Widths, result codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rti_pkg;

  localparam int CW     = 16;          // coordinate width
  localparam int EW     = CW + 1;      // edge / offset width
  localparam int PMW    = CW + EW;     // dir x e2 product
  localparam int QMW    = EW + EW;     // s x e1 product
  localparam int PW     = PMW + 1;     // p component
  localparam int QW     = QMW + 1;     // q component
  localparam int NW     = EW + QW + 2; // numerators incl. sums
  localparam int MW     = NW - 1;      // magnitude after sign fix
  localparam int DFRAC  = 16;          // distance fraction bits
  localparam int DISTW  = 32;
  localparam int IDXW   = 3;

  typedef enum logic [2:0] {
    REASON_HIT      = 3'd0,
    REASON_PARALLEL = 3'd1,
    REASON_U        = 3'd2,
    REASON_V        = 3'd3,
    REASON_BEHIND   = 3'd4
  } reason_t;

  typedef enum logic [IDXW-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] dz;
  } ray_t;

  typedef struct packed {
    reason_t reason;
    logic    sat;
  } rti_meta_t;

endpackage

@@ src/ray_triangle_intersect_core.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersect core
// Moller-Trumbore test of a configured ray against a stream of triangles.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (index 0..5 = origin x,y,z, direction x,y,z),
//            always ready; write only while no triangle is in flight.
//   in_*   : one triangle per transfer (three signed Q8.8 vertices).
//   out_*  : one result per triangle, in order: hit, Q16.16 distance
//            (saturated, 0 on miss) and miss reason.
// From input transfer to output valid a triangle passes 7 arithmetic
// stages, 32 divider stages (one quotient bit each) and the output register.
// Throughput is one triangle per cycle while the receiver takes results,
// set by the fully pipelined multipliers and divider stages.
// Each stage advances when it is empty or its successor moves, so a stalled
// receiver fills the bubbles first; in_ready drops only once every stage
// holds an item. Nothing is lost or repeated during a stall.
// Reset (rst_n low at a clock edge) empties the pipeline and sets the ray
// to origin 0 and direction (0, 0, 1.0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_triangle_intersect_core_defines.svh"
module ray_triangle_intersect_core import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDXW-1:0]      cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_vert0_x,
  input  logic signed [CW-1:0] in_vert0_y,
  input  logic signed [CW-1:0] in_vert0_z,
  input  logic signed [CW-1:0] in_vert1_x,
  input  logic signed [CW-1:0] in_vert1_y,
  input  logic signed [CW-1:0] in_vert1_z,
  input  logic signed [CW-1:0] in_vert2_x,
  input  logic signed [CW-1:0] in_vert2_y,
  input  logic signed [CW-1:0] in_vert2_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [DISTW-1:0]     out_distance,
  output logic [2:0]           out_miss_reason
);

  ray_t ray_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.ox <= '0;
      ray_r.oy <= '0;
      ray_r.oz <= '0;
      ray_r.dx <= '0;
      ray_r.dy <= '0;
      ray_r.dz <= CW'(1 << 8);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORG_X: ray_r.ox <= cfg_data;
        REG_ORG_Y: ray_r.oy <= cfg_data;
        REG_ORG_Z: ray_r.oz <= cfg_data;
        REG_DIR_X: ray_r.dx <= cfg_data;
        REG_DIR_Y: ray_r.dy <= cfg_data;
        REG_DIR_Z: ray_r.dz <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             f_valid, f_ready;
  logic [MW-1:0]    f_tn, f_det;
  rti_meta_t        f_meta;
  logic             d_valid, d_ready;
  logic [DISTW-1:0] d_quot;
  rti_meta_t        d_meta;

  rti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ray      (ray_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .v0x      (in_vert0_x),
    .v0y      (in_vert0_y),
    .v0z      (in_vert0_z),
    .v1x      (in_vert1_x),
    .v1y      (in_vert1_y),
    .v1z      (in_vert1_z),
    .v2x      (in_vert2_x),
    .v2y      (in_vert2_y),
    .v2z      (in_vert2_z),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_tn    (f_tn),
    .dn_det   (f_det),
    .dn_meta  (f_meta)
  );

  rti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_tn    (f_tn),
    .up_det   (f_det),
    .up_meta  (f_meta),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_quot  (d_quot),
    .dn_meta  (d_meta)
  );

  logic             out_valid_r;
  logic             out_hit_r;
  logic [DISTW-1:0] out_distance_r;
  reason_t          out_reason_r;
  logic             is_hit;

  assign d_ready = !out_valid_r || out_ready;
  assign is_hit  = (d_meta.reason == REASON_HIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      out_hit_r      <= is_hit;
      out_reason_r   <= d_meta.reason;
      out_distance_r <= !is_hit ? '0 : (d_meta.sat ? '1 : d_quot);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_distance    = out_distance_r;
  assign out_miss_reason = out_reason_r;

  `RTI_ASSERT_IMP(a_hit_code, out_valid && out_hit, out_miss_reason == REASON_HIT, "hit with miss code")
  `RTI_ASSERT_IMP(a_miss_dist, out_valid && !out_hit, out_distance == '0, "miss with distance")
  `RTI_ASSERT_IMP(a_empty_ready, !out_valid_r, in_ready, "stall with empty output")
  `RTI_ASSERT_NXT(a_drain, out_valid && out_ready && !d_valid, !out_valid, "output not drained")

endmodule

@@ src/rti_front.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle front end
// Seven-stage pipeline: edges, cross products, dot products, sign fix, tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ray_t                 ray,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [CW-1:0] v0x,
  input  logic signed [CW-1:0] v0y,
  input  logic signed [CW-1:0] v0z,
  input  logic signed [CW-1:0] v1x,
  input  logic signed [CW-1:0] v1y,
  input  logic signed [CW-1:0] v1z,
  input  logic signed [CW-1:0] v2x,
  input  logic signed [CW-1:0] v2y,
  input  logic signed [CW-1:0] v2z,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [MW-1:0]        dn_tn,
  output logic [MW-1:0]        dn_det,
  output rti_meta_t            dn_meta
);

  localparam int NS = 7;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: edges and origin offset
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] s_r  [3];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      e1_r[0] <= EW'(v1x) - EW'(v0x);
      e1_r[1] <= EW'(v1y) - EW'(v0y);
      e1_r[2] <= EW'(v1z) - EW'(v0z);
      e2_r[0] <= EW'(v2x) - EW'(v0x);
      e2_r[1] <= EW'(v2y) - EW'(v0y);
      e2_r[2] <= EW'(v2z) - EW'(v0z);
      s_r[0]  <= EW'(ray.ox) - EW'(v0x);
      s_r[1]  <= EW'(ray.oy) - EW'(v0y);
      s_r[2]  <= EW'(ray.oz) - EW'(v0z);
    end
  end

  // stage 2: cross product terms
  logic signed [PMW-1:0] pm_r [6];
  logic signed [QMW-1:0] qm_r [6];
  logic signed [EW-1:0]  e1b_r [3];
  logic signed [EW-1:0]  e2b_r [3];
  logic signed [EW-1:0]  sb_r  [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pm_r[0] <= ray.dy * e2_r[2];
      pm_r[1] <= ray.dz * e2_r[1];
      pm_r[2] <= ray.dz * e2_r[0];
      pm_r[3] <= ray.dx * e2_r[2];
      pm_r[4] <= ray.dx * e2_r[1];
      pm_r[5] <= ray.dy * e2_r[0];
      qm_r[0] <= s_r[1] * e1_r[2];
      qm_r[1] <= s_r[2] * e1_r[1];
      qm_r[2] <= s_r[2] * e1_r[0];
      qm_r[3] <= s_r[0] * e1_r[2];
      qm_r[4] <= s_r[0] * e1_r[1];
      qm_r[5] <= s_r[1] * e1_r[0];
      e1b_r   <= e1_r;
      e2b_r   <= e2_r;
      sb_r    <= s_r;
    end
  end

  // stage 3: p = dir x e2, q = s x e1
  logic signed [PW-1:0] p_r [3];
  logic signed [QW-1:0] q_r [3];
  logic signed [EW-1:0] e1c_r [3];
  logic signed [EW-1:0] e2c_r [3];
  logic signed [EW-1:0] sc_r  [3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= PW'(pm_r[2*i]) - PW'(pm_r[2*i+1]);
        q_r[i] <= QW'(qm_r[2*i]) - QW'(qm_r[2*i+1]);
      end
      e1c_r <= e1b_r;
      e2c_r <= e2b_r;
      sc_r  <= sb_r;
    end
  end

  // stage 4: dot product terms
  logic signed [EW+PW-1:0] dm_r [3];
  logic signed [EW+PW-1:0] um_r [3];
  logic signed [CW+QW-1:0] vm_r [3];
  logic signed [EW+QW-1:0] tm_r [3];
  logic signed [CW-1:0]    dirv [3];

  assign dirv[0] = ray.dx;
  assign dirv[1] = ray.dy;
  assign dirv[2] = ray.dz;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        dm_r[i] <= e1c_r[i] * p_r[i];
        um_r[i] <= sc_r[i] * p_r[i];
        vm_r[i] <= dirv[i] * q_r[i];
        tm_r[i] <= e2c_r[i] * q_r[i];
      end
    end
  end

  // stage 5: sums
  logic signed [NW-1:0] det5_r, un5_r, vn5_r, tn5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      det5_r <= NW'(dm_r[0]) + NW'(dm_r[1]) + NW'(dm_r[2]);
      un5_r  <= NW'(um_r[0]) + NW'(um_r[1]) + NW'(um_r[2]);
      vn5_r  <= NW'(vm_r[0]) + NW'(vm_r[1]) + NW'(vm_r[2]);
      tn5_r  <= NW'(tm_r[0]) + NW'(tm_r[1]) + NW'(tm_r[2]);
    end
  end

  // stage 6: make det non-negative
  logic signed [NW-1:0] det6_r, un6_r, vn6_r, tn6_r;
  logic                 zero6_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      zero6_r <= (det5_r == '0);
      if (det5_r[NW-1]) begin
        det6_r <= -det5_r;
        un6_r  <= -un5_r;
        vn6_r  <= -vn5_r;
        tn6_r  <= -tn5_r;
      end else begin
        det6_r <= det5_r;
        un6_r  <= un5_r;
        vn6_r  <= vn5_r;
        tn6_r  <= tn5_r;
      end
    end
  end

  // stage 7: range tests
  reason_t                  reason_nxt;
  logic signed [NW-1:0]     rem_w;
  logic [MW+DFRAC-1:0]      tn_ext, det_sh;
  logic [MW-1:0]            tn7_r, det7_r;
  rti_meta_t                meta7_r;

  always_comb begin
    rem_w  = det6_r - un6_r;
    tn_ext = {{DFRAC{1'b0}}, tn6_r[MW-1:0]};
    det_sh = {det6_r[MW-1:0], {DFRAC{1'b0}}};
    if (zero6_r) begin
      reason_nxt = REASON_PARALLEL;
    end else if (un6_r < 0 || un6_r > det6_r) begin
      reason_nxt = REASON_U;
    end else if (vn6_r < 0 || vn6_r > rem_w) begin
      reason_nxt = REASON_V;
    end else if (tn6_r < 0) begin
      reason_nxt = REASON_BEHIND;
    end else begin
      reason_nxt = REASON_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      tn7_r          <= tn6_r[MW-1:0];
      det7_r         <= det6_r[MW-1:0];
      meta7_r.reason <= reason_nxt;
      meta7_r.sat    <= (tn_ext >= det_sh);
    end
  end

  assign dn_tn   = tn7_r;
  assign dn_det  = det7_r;
  assign dn_meta = meta7_r;

endmodule

@@ src/rti_div.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle distance divider
// Restoring divider, one quotient bit per pipeline stage, Q16.16 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [MW-1:0]    up_tn,
  input  logic [MW-1:0]    up_det,
  input  rti_meta_t        up_meta,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [DISTW-1:0] dn_quot,
  output rti_meta_t        dn_meta
);

  localparam int NS = DISTW;

  logic [NS-1:0]    v_r;
  logic [NS:0]      rdy;
  logic [MW-1:0]    r_r    [NS];
  logic [MW-1:0]    d_r    [NS];
  logic [DFRAC-1:0] lo_r   [NS];
  logic [DISTW-1:0] q_r    [NS];
  rti_meta_t        meta_r [NS];

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign dn_quot  = q_r[NS-1];
  assign dn_meta  = meta_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [MW-1:0]    r_in, d_in;
    logic [DFRAC-1:0] lo_in;
    logic [DISTW-1:0] q_in;
    rti_meta_t        m_in;
    logic [MW:0]      trial, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in  = {{DFRAC{1'b0}}, up_tn[MW-1:DFRAC]};
      assign lo_in = up_tn[DFRAC-1:0];
      assign d_in  = up_det;
      assign q_in  = '0;
      assign m_in  = up_meta;
    end else begin : g_next
      assign r_in  = r_r[k-1];
      assign lo_in = lo_r[k-1];
      assign d_in  = d_r[k-1];
      assign q_in  = q_r[k-1];
      assign m_in  = meta_r[k-1];
    end

    always_comb begin
      trial = {r_in, lo_in[DFRAC-1]};
      diff  = trial - {1'b0, d_in};
      ge    = (trial >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        r_r[k]    <= ge ? diff[MW-1:0] : trial[MW-1:0];
        lo_r[k]   <= {lo_in[DFRAC-2:0], 1'b0};
        d_r[k]    <= d_in;
        q_r[k]    <= {q_in[DISTW-2:0], ge};
        meta_r[k] <= m_in;
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersect core testbench
// Streams triangles against several configured rays and compares each result
// (hit, Q16.16 distance, miss reason) with an exact integer prediction of the
// Moller-Trumbore test. Both handshakes idle at random, with one phase clean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import rti_pkg::*;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t tri_t [9];

  typedef struct {
    logic             hit;
    logic [DISTW-1:0] distance;
    reason_t          reason;
  } hit_result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDXW-1:0]  cfg_index = '0;
  logic [CW-1:0]    cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  coord_t           vert [9];
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_hit;
  logic [DISTW-1:0] out_distance;
  logic [2:0]       out_miss_reason;

  longint           ray_org [3];
  longint           ray_dir [3];
  hit_result_t      expected_hits [$];
  bit               steady = 1'b0;
  int               errors = 0;
  int               tri_count = 0;
  int               hit_count = 0;
  int               reason_seen [5];
  int               idle_cycles = 0;

  initial begin
    foreach (vert[i]) vert[i] = '0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ray_triangle_intersect_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vert0_x(vert[0]), .in_vert0_y(vert[1]), .in_vert0_z(vert[2]),
    .in_vert1_x(vert[3]), .in_vert1_y(vert[4]), .in_vert1_z(vert[5]),
    .in_vert2_x(vert[6]), .in_vert2_y(vert[7]), .in_vert2_z(vert[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_distance(out_distance),
    .out_miss_reason(out_miss_reason)
  );

  function automatic void cross3(input longint a [3], input longint b [3],
                                 output longint r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic hit_result_t predict_tri(input tri_t t);
    longint      e1 [3], e2 [3], s [3], p [3], q [3];
    longint      det, un, vn, tn;
    logic [127:0] num;
    hit_result_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t[3+i]) - longint'(t[i]);
      e2[i] = longint'(t[6+i]) - longint'(t[i]);
      s[i]  = ray_org[i] - longint'(t[i]);
    end
    cross3(ray_dir, e2, p);
    cross3(s, e1, q);
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    un  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    vn  = ray_dir[0]*q[0] + ray_dir[1]*q[1] + ray_dir[2]*q[2];
    tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    r.hit = 1'b0;
    r.distance = '0;
    if (det == 0) begin
      r.reason = REASON_PARALLEL;
      return r;
    end
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det) r.reason = REASON_U;
    else if (vn < 0 || vn > det - un) r.reason = REASON_V;
    else if (tn < 0) r.reason = REASON_BEHIND;
    else begin
      r.hit = 1'b1;
      r.reason = REASON_HIT;
      if (tn / det >= 65536) r.distance = '1;
      else begin
        num = 128'(tn) << DFRAC;
        r.distance = DISTW'(num / 128'(det));
      end
    end
    return r;
  endfunction

  // stimulus side
  task automatic send_tri(input tri_t t);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    foreach (vert[i]) vert[i] = t[i];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_hits.push_back(predict_tri(t));
    tri_count++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    end_burst();
    wait (expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input coord_t value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_ORG_Z) ray_org[idx] = longint'(value);
    else ray_dir[idx - REG_DIR_X] = longint'(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_ray(input coord_t ox, oy, oz, dx, dy, dz);
    wait_idle();
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  function automatic coord_t clamp(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return coord_t'(v);
  endfunction

  // triangle placed around a point on the ray, or pure noise
  function automatic tri_t rand_tri(input int spread);
    tri_t   t;
    longint k, c;
    if ($urandom_range(99) < 15) begin
      foreach (t[i]) t[i] = coord_t'($urandom);
      return t;
    end
    k = longint'($urandom_range(0, 2048)) - 256;
    for (int a = 0; a < 3; a++) begin
      c = ray_org[a] + (k * ray_dir[a]) / 256;
      for (int v = 0; v < 3; v++)
        t[3*v+a] = clamp(c + longint'($urandom_range(0, 2*spread)) - spread);
    end
    return t;
  endfunction

  task automatic test_directed_default_ray();
    tri_t t;
    t = '{-256, -256, 512, 768, -256, 512, -256, 768, 512};  send_tri(t);
    t = '{0, 0, 512, 256, 0, 512, 0, 256, 512};               send_tri(t);
    t = '{-256, 0, 512, 0, 0, 512, 0, 256, 512};              send_tri(t);
    t = '{256, 0, 512, 0, 256, 512, 0, 0, 768};               send_tri(t);
    t = '{-256, -256, 0, 768, -256, 0, -256, 768, 0};         send_tri(t);
    t = '{-256, -256, -512, 768, -256, -512, -256, 768, -512}; send_tri(t);
    t = '{256, -256, 512, 768, -256, 512, 256, 768, 512};     send_tri(t);
    t = '{-256, 256, 512, 768, 256, 512, -256, 768, 512};     send_tri(t);
    t = '{-768, -256, 512, 256, -256, 512, 256, 768, 512};    send_tri(t);
    t = '{100, 100, 100, 100, 100, 100, 100, 100, 100};       send_tri(t);
    t = '{0, 0, 0, 256, 0, 0, 512, 0, 0};                     send_tri(t);
    t = '{-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 32767};
    send_tri(t);
    t = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
          -32768};
    send_tri(t);
    t = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_tri(t);
    t = '{-32768, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767};
    send_tri(t);
    t = '{-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 0};
    send_tri(t);
  endtask

  task automatic test_saturated_distance();
    tri_t t;
    set_ray(0, 0, 0, 0, 0, 1);
    t = '{-256, -256, 32767, 768, -256, 32767, -256, 768, 32767}; send_tri(t);
    t = '{-256, -256, 256, 768, -256, 256, -256, 768, 256};       send_tri(t);
    set_ray(0, 0, 0, 0, 0, 0);
    t = '{-256, -256, 512, 768, -256, 512, -256, 768, 512};       send_tri(t);
    set_ray(-32768, -32768, -32768, 32767, 32767, 32767);
    t = '{0, 0, 0, 32767, 0, 0, 0, 32767, 0};                     send_tri(t);
    t = '{-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 32767};
    send_tri(t);
    set_ray(32767, 32767, 32767, -32768, -32768, -32768);
    t = '{0, 0, 0, 32767, 0, 0, 0, 32767, 0};                     send_tri(t);
  endtask

  task automatic test_random_ray(input coord_t ox, oy, oz, dx, dy, dz,
                                 input int count, input bit clean);
    set_ray(ox, oy, oz, dx, dy, dz);
    steady = clean;
    repeat (count) send_tri(rand_tri(($urandom_range(99) < 80) ? 600 : 8000));
    steady = 1'b0;
  endtask

  // result side
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    hit_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $error("result transfer with no triangle outstanding");
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0b actual %0b", e.hit, out_hit);
          errors++;
        end
        if (out_distance !== e.distance) begin
          $error("distance: expected %h actual %h", e.distance, out_distance);
          errors++;
        end
        if (out_miss_reason !== e.reason) begin
          $error("miss_reason: expected %0d actual %0d", e.reason,
                 out_miss_reason);
          errors++;
        end
        hit_count += e.hit;
        reason_seen[e.reason]++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, 256};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_default_ray();
    test_saturated_distance();
    test_random_ray(0, 0, 0, 0, 0, 256, 330, 1'b0);
    test_random_ray(100, -200, 50, 256, 128, -64, 330, 1'b1);
    test_random_ray(-3000, 2500, 1000, -37, 300, 91, 330, 1'b0);
    test_random_ray(32767, -32768, 0, -32768, 32767, 1, 330, 1'b0);
    test_random_ray(-500, 700, -900, 12000, -7000, 20000, 330, 1'b0);
    wait_idle();
    $display("%0d triangles over 10 ray settings, %0d hits", tri_count, hit_count);
    $display("misses: parallel %0d, u %0d, v %0d, behind %0d", reason_seen[1],
             reason_seen[2], reason_seen[3], reason_seen[4]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
